### rtl/core/cipher_rotor_substitution_assert.svh
// Assertion macros used by the rotor substitution top level.
`ifndef CIPHER_ROTOR_SUBSTITUTION_ASSERT_SVH
`define CIPHER_ROTOR_SUBSTITUTION_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CRS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CRS_ASSERT(lbl, prop, msg)
`define CRS_ASSERT_RST(lbl, prop, msg)
`endif

`endif

### rtl/core/crs_pkg.sv
// Package with rotor wiring tables, notch constants, command codes and shared types.
`default_nettype none
package crs_pkg;

  localparam int NUM_LETTERS = 26;
  localparam int NUM_TYPES   = 9;
  localparam int NUM_SINGLE  = 5;

  localparam logic [3:0] SLOT_IDENTITY = 4'(NUM_TYPES - 1);
  localparam logic [4:0] NOTCH_Z       = 5'd25;
  localparam logic [4:0] NOTCH_M       = 5'd12;
  localparam logic [4:0] LETTER_LAST   = 5'(NUM_LETTERS - 1);

  typedef enum logic [1:0] {
    CMD_FWD     = 2'd0,
    CMD_BWD     = 2'd1,
    CMD_ROTATE  = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_ROTOR_TYPE     = 2'd0,
    REG_RING_SETTING   = 2'd1,
    REG_START_POSITION = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [3:0] slot;
    logic [4:0] ring;
    logic [4:0] start;
    logic [4:0] pos;
  } rotor_cfg_t;

  typedef struct packed {
    logic fire;
    cmd_t cmd;
  } step_t;

  localparam logic [8*NUM_LETTERS-1:0] WIRING [NUM_TYPES] = '{
    "EKMFLGDQVZNTOWYHXUSPAIBRCJ",
    "AJDKSIRUXBLHWTMCQGZNPYFVOE",
    "BDFHJLCPRTXVZNYEIWGAKMUSQO",
    "ESOVPZJAYQUIRHXLNFTGKDCMWB",
    "VZBRGITYUPSDNHLXAWMJQOFECK",
    "JPGVOUMFYQBENHZRDKASXLICTW",
    "NZJHGRCXMYSWBOUFAIVLPEKQDT",
    "FKQHTLXOCBJSPDZRAMEWNIUYGV",
    "ABCDEFGHIJKLMNOPQRSTUVWXYZ"
  };

  localparam logic [4:0] NOTCH_ONE [NUM_SINGLE] = '{
    5'd16, 5'd4, 5'd21, 5'd9, 5'd25
  };

  function automatic logic [4:0] wrap26(input logic [5:0] v);
    logic [5:0] d;
    d = v - 6'(NUM_LETTERS);
    if (v >= 6'(NUM_LETTERS)) begin
      return d[4:0];
    end
    return v[4:0];
  endfunction

  function automatic logic [4:0] wire_fwd(input logic [3:0] slot, input logic [4:0] idx);
    logic [7:0] ch;
    logic [7:0] d;
    logic [3:0] s;
    logic [4:0] k;
    s = (slot > SLOT_IDENTITY) ? SLOT_IDENTITY : slot;
    k = (idx > LETTER_LAST) ? LETTER_LAST : idx;
    ch = WIRING[s][8*(LETTER_LAST - k) +: 8];
    d = ch - 8'd65;
    return d[4:0];
  endfunction

endpackage
`default_nettype wire

### rtl/core/crs_rotor_state.sv
// Configuration registers and rotor position counter.
`default_nettype none
module crs_rotor_state import crs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data,
  input  step_t      step,
  output rotor_cfg_t rotor
);

  logic [3:0] slot_r, slot_nxt;
  logic [4:0] ring_r, ring_nxt;
  logic [4:0] start_r, start_nxt;
  logic [4:0] pos_r, pos_nxt;
  logic [4:0] data_wrap;
  logic [3:0] type_raw;

  assign data_wrap = wrap26({1'b0, cfg_data});
  assign type_raw  = cfg_data[3:0];

  always_comb begin
    slot_nxt  = slot_r;
    ring_nxt  = ring_r;
    start_nxt = start_r;
    pos_nxt   = pos_r;
    if (step.fire) begin
      case (step.cmd)
        CMD_ROTATE:  pos_nxt = (pos_r == LETTER_LAST) ? 5'd0 : pos_r + 5'd1;
        CMD_RESTART: pos_nxt = start_r;
        default:     pos_nxt = pos_r;
      endcase
    end
    if (cfg_we) begin
      unique case (cfg_index)
        REG_ROTOR_TYPE: begin
          if (type_raw >= 4'd1 && type_raw <= 4'(NUM_TYPES)) begin
            slot_nxt = type_raw - 4'd1;
          end else begin
            slot_nxt = SLOT_IDENTITY;
          end
        end
        REG_RING_SETTING: ring_nxt = data_wrap;
        REG_START_POSITION: begin
          start_nxt = data_wrap;
          pos_nxt   = data_wrap;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= 4'd0;
      ring_r  <= 5'd0;
      start_r <= 5'd0;
      pos_r   <= 5'd0;
    end else begin
      slot_r  <= slot_nxt;
      ring_r  <= ring_nxt;
      start_r <= start_nxt;
      pos_r   <= pos_nxt;
    end
  end

  assign rotor.slot  = slot_r;
  assign rotor.ring  = ring_r;
  assign rotor.start = start_r;
  assign rotor.pos   = pos_r;

endmodule
`default_nettype wire

### rtl/core/crs_substitute.sv
// Combinational substitution through the forward or inverse wiring, plus notch check.
`default_nettype none
module crs_substitute import crs_pkg::*; (
  input  cmd_t       cmd,
  input  logic [4:0] letter_in,
  input  rotor_cfg_t rotor,
  output logic [4:0] letter_out,
  output logic       at_notch
);

  logic [4:0] letter_w;
  logic [4:0] shift;
  logic [4:0] idx;
  logic [4:0] fwd;
  logic [4:0] bwd;
  logic [4:0] sub;
  logic [4:0] res;

  assign letter_w = wrap26({1'b0, letter_in});
  assign shift    = wrap26({1'b0, rotor.pos} + 6'(NUM_LETTERS) - {1'b0, rotor.ring});
  assign idx      = wrap26({1'b0, letter_w} + {1'b0, shift});
  assign fwd      = wire_fwd(rotor.slot, idx);

  always_comb begin
    bwd = 5'd0;
    for (int i = 0; i < NUM_LETTERS; i++) begin
      if (wire_fwd(rotor.slot, 5'(i)) == idx) begin
        bwd = 5'(i);
      end
    end
  end

  assign sub = (cmd == CMD_FWD) ? fwd : bwd;
  assign res = wrap26({1'b0, sub} + 6'(NUM_LETTERS) - {1'b0, shift});

  always_comb begin
    case (cmd)
      CMD_FWD, CMD_BWD: letter_out = res;
      default:          letter_out = 5'd0;
    endcase
  end

  always_comb begin
    if (rotor.slot < 4'(NUM_SINGLE)) begin
      at_notch = (rotor.pos == NOTCH_ONE[rotor.slot[2:0]]);
    end else begin
      at_notch = (rotor.pos == NOTCH_Z) || (rotor.pos == NOTCH_M);
    end
  end

endmodule
`default_nettype wire

### rtl/core/cipher_rotor_substitution.sv
// Top level of the rotor substitution block: input stage, result stage and handshakes.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_ready     in_cmd, in_letter_in
//   out      output     out_valid / out_ready   out_letter_out, out_at_notch
//   cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One transaction per cycle unless out stalls; results pass the input then result stage.
// On rotate or restart the position counter updates as the item leaves the input stage.
// Reset clears both stages and loads type 1, ring 0, start 0, position 0.
// A stall on out backs up one transaction in the input stage, then drops in_ready.
// cfg_ready is always high.
`default_nettype none
`include "cipher_rotor_substitution_assert.svh"
module cipher_rotor_substitution import crs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  input  logic [4:0] in_letter_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] out_letter_out,
  output logic       out_at_notch,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data
);

  logic       s1_vld_r, s1_vld_nxt;
  cmd_t       s1_cmd_r;
  logic [4:0] s1_letter_r;
  logic       out_vld_r, out_vld_nxt;
  logic [4:0] out_letter_r;
  logic       out_notch_r;
  logic       s2_fire;
  logic       in_fire;
  logic [4:0] sub_letter;
  logic       sub_notch;
  rotor_cfg_t rotor;
  step_t      step;

  assign cfg_ready = 1'b1;
  assign s2_fire   = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !s1_vld_r || s2_fire;
  assign in_fire   = in_valid && in_ready;

  assign step.fire = s2_fire;
  assign step.cmd  = s1_cmd_r;

  crs_rotor_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .rotor     (rotor)
  );

  crs_substitute u_sub (
    .cmd        (s1_cmd_r),
    .letter_in  (s1_letter_r),
    .rotor      (rotor),
    .letter_out (sub_letter),
    .at_notch   (sub_notch)
  );

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_ready) begin
      s1_vld_nxt = in_valid;
    end
    out_vld_nxt = out_vld_r;
    if (s2_fire) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r    <= cmd_t'(in_cmd);
      s1_letter_r <= in_letter_in;
    end
    if (s2_fire) begin
      out_letter_r <= sub_letter;
      out_notch_r  <= sub_notch;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_letter_out = out_letter_r;
  assign out_at_notch   = out_notch_r;

  `CRS_ASSERT(a_pos_range, rotor.pos < 5'(NUM_LETTERS), "position out of range")
  `CRS_ASSERT(a_out_range, out_vld_r |-> out_letter_r < 5'(NUM_LETTERS), "letter out of range")
  `CRS_ASSERT(a_stall_cause, !in_ready |-> (s1_vld_r && out_vld_r && !out_ready), "bad stall")
  `CRS_ASSERT(a_rotate, (s2_fire && s1_cmd_r == CMD_ROTATE && !cfg_valid) |=>
    (rotor.pos == (($past(rotor.pos) == LETTER_LAST) ? 5'd0 : $past(rotor.pos) + 5'd1)),
    "rotate did not advance")
  `CRS_ASSERT_RST(a_reset_out, !rst_n |=> !out_vld_r, "result valid after reset")

endmodule
`default_nettype wire
